FILE: hdl/assert_macros.svh
// Assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AST_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_IMP(lbl, clk, rst_n, ante, cons)
`define AST_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/lclip_pkg.sv
package lclip_pkg;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_LEFT   = 2'd0;
  localparam reg_idx_t REG_TOP    = 2'd1;
  localparam reg_idx_t REG_RIGHT  = 2'd2;
  localparam reg_idx_t REG_BOTTOM = 2'd3;

  localparam logic [3:0] OC_TOP    = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_LEFT   = 4'd8;

  localparam logic [2:0] CLIP_PASSES = 3'd4;

  typedef struct packed {
    logic load;
    logic setup;
    logic mul_step;
    logic div_step;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic settled;
    logic in_rect;
  } sts_t;

endpackage

FILE: hdl/lclip_ctrl.sv
module lclip_ctrl #(
  parameter int COORD_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  lclip_pkg::sts_t sts,
  output lclip_pkg::cmd_t cmd
);

  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;
  localparam int CNT_W = $clog2(PW + 1);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_MUL, S_DIV, S_UPD, S_DONE} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [2:0]       pass_r;
  logic             out_valid_r;
  logic             slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_tvalid;
    cmd.setup    = (state_r == S_CHECK) && !sts.settled && (pass_r != lclip_pkg::CLIP_PASSES);
    cmd.mul_step = (state_r == S_MUL);
    cmd.div_step = (state_r == S_DIV);
    cmd.update   = (state_r == S_UPD);
    cmd.out_load = (state_r == S_DONE) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load)    out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            pass_r  <= '0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          cnt_r <= '0;
          if (cmd.setup) state_r <= S_MUL;
          else           state_r <= S_DONE;
        end
        S_MUL: begin
          if (cnt_r == CNT_W'(DW - 1)) begin
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIV: begin
          if (cnt_r == CNT_W'(PW - 1)) state_r <= S_UPD;
          else                         cnt_r   <= cnt_r + 1'b1;
        end
        S_UPD: begin
          pass_r  <= pass_r + 1'b1;
          state_r <= S_CHECK;
        end
        S_DONE: begin
          if (slot_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/lclip_dp.sv
module lclip_dp #(
  parameter int COORD_BITS = 16
) (
  input  logic                       clk,
  input  logic                       cfg_we,
  input  lclip_pkg::reg_idx_t        cfg_index,
  input  logic [COORD_BITS-1:0]      cfg_wdata,
  input  logic [4*COORD_BITS-1:0]    in_coords,
  output logic [4*COORD_BITS-1:0]    out_coords,
  output logic                       out_inside,
  input  lclip_pkg::cmd_t            cmd,
  output lclip_pkg::sts_t            sts,
  input  logic                       rst_n
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic signed [CW-1:0] left_r, top_r, right_r, bottom_r;
  logic signed [CW-1:0] px_r, py_r, qx_r, qy_r;
  logic signed [CW-1:0] base_r, edge_r;
  logic                 horiz_r, to_p_r, neg_r;
  logic [PW-1:0]        acc_r, mcand_r;
  logic [DW-1:0]        mplier_r, den_r, rem_r;
  logic [4*CW-1:0]      out_coords_r;
  logic                 out_inside_r;

  logic [3:0]           cp, cq, co;
  logic signed [DW-1:0] dlt, num, den;
  logic signed [CW-1:0] base_v, edge_v;
  logic                 horiz_v;
  logic [DW:0]          trial;
  logic [DW-1:0]        quo;
  logic signed [DW-1:0] squo;
  logic signed [DW:0]   res_w;
  logic signed [CW-1:0] res;

  function automatic logic [3:0] outcode(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y);
    logic [3:0] c;
    c = 4'd0;
    if (y < top_r)         c = lclip_pkg::OC_TOP;
    else if (y > bottom_r) c = lclip_pkg::OC_BOTTOM;
    if (x > right_r)       c = c | lclip_pkg::OC_RIGHT;
    else if (x < left_r)   c = c | lclip_pkg::OC_LEFT;
    return c;
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  assign cp = outcode(px_r, py_r);
  assign cq = outcode(qx_r, qy_r);
  assign co = (cp != 4'd0) ? cp : cq;
  assign sts.in_rect = ((cp | cq) == 4'd0);
  assign sts.settled = sts.in_rect || ((cp & cq) != 4'd0);

  // pick the edge and the interpolation terms for this pass
  always_comb begin
    horiz_v = 1'b1;
    base_v  = px_r;
    edge_v  = top_r;
    dlt     = DW'(qx_r) - DW'(px_r);
    num     = DW'(top_r) - DW'(py_r);
    den     = DW'(qy_r) - DW'(py_r);
    if ((co & lclip_pkg::OC_TOP) != 4'd0) begin
      edge_v = top_r;
    end else if ((co & lclip_pkg::OC_BOTTOM) != 4'd0) begin
      edge_v = bottom_r;
      num    = DW'(bottom_r) - DW'(py_r);
    end else begin
      horiz_v = 1'b0;
      base_v  = py_r;
      edge_v  = ((co & lclip_pkg::OC_RIGHT) != 4'd0) ? right_r : left_r;
      dlt     = DW'(qy_r) - DW'(py_r);
      num     = DW'(edge_v) - DW'(px_r);
      den     = DW'(qx_r) - DW'(px_r);
    end
  end

  assign trial = {rem_r, acc_r[PW-1]};
  assign quo   = acc_r[DW-1:0];
  assign squo  = neg_r ? -$signed(quo) : $signed(quo);
  assign res_w = (DW+1)'(base_r) + (DW+1)'(squo);
  assign res   = res_w[CW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= CW'(1023);
      bottom_r <= CW'(1023);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lclip_pkg::REG_LEFT:   left_r   <= cfg_wdata;
        lclip_pkg::REG_TOP:    top_r    <= cfg_wdata;
        lclip_pkg::REG_RIGHT:  right_r  <= cfg_wdata;
        lclip_pkg::REG_BOTTOM: bottom_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= in_coords[CW-1:0];
      py_r <= in_coords[2*CW-1:CW];
      qx_r <= in_coords[3*CW-1:2*CW];
      qy_r <= in_coords[4*CW-1:3*CW];
    end
    if (cmd.setup) begin
      mcand_r  <= PW'(mag(dlt));
      mplier_r <= mag(num);
      den_r    <= mag(den);
      acc_r    <= '0;
      rem_r    <= '0;
      neg_r    <= (dlt[DW-1] ^ num[DW-1]) ^ den[DW-1];
      base_r   <= base_v;
      edge_r   <= edge_v;
      horiz_r  <= horiz_v;
      to_p_r   <= (cp != 4'd0);
    end
    // shift-add multiply, one multiplier bit a beat
    if (cmd.mul_step) begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
    // restoring divide, quotient shifts into acc from the bottom
    if (cmd.div_step) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= DW'(trial - {1'b0, den_r});
        acc_r <= {acc_r[PW-2:0], 1'b1};
      end else begin
        rem_r <= trial[DW-1:0];
        acc_r <= {acc_r[PW-2:0], 1'b0};
      end
    end
    if (cmd.update) begin
      if (to_p_r) begin
        px_r <= horiz_r ? res : edge_r;
        py_r <= horiz_r ? edge_r : res;
      end else begin
        qx_r <= horiz_r ? res : edge_r;
        qy_r <= horiz_r ? edge_r : res;
      end
    end
    if (cmd.out_load) begin
      out_coords_r <= {qy_r, qx_r, py_r, px_r};
      out_inside_r <= sts.in_rect;
    end
  end

  assign out_coords = out_coords_r;
  assign out_inside = out_inside_r;

endmodule

FILE: hdl/line_clip_to_rectangle_core.sv
// Cohen-Sutherland clipper for one 2D line segment at a time.
// Input beat (in_*): the segment's two endpoints; accepted when
// in_tvalid and in_tready are both high. Output beat (out_*): the endpoints
// as clipped, with out_tuser high when the segment lies inside the rectangle.
// The rectangle sits in four registers written through cfg_we/cfg_index/
// cfg_wdata (left, top, right, bottom); write them only while idle.
// Each item runs up to four clip passes on one shared unit: a shift-add
// multiply, then a restoring divide, then an update and a check state;
// one item is in work at a time.
// The result sits in an output register, so in_tready returns while it
// waits; a stalled receiver holds the next result in the unit until the
// register frees, and in_tready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the unit and output and sets the
// rectangle to left 0, top 0, right 1023, bottom 1023.
`include "assert_macros.svh"
module line_clip_to_rectangle_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  lclip_pkg::reg_idx_t                 cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // start_x, start_y, end_x, end_y, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_start_x, out_start_y, out_end_x, out_end_y, zero pad
  output logic [((4*COORD_BITS+7)/8)*8-1:0]   out_tdata,
  // accepted
  output logic                                out_tuser
);

  localparam int TW = ((4*COORD_BITS+7)/8)*8;

  lclip_pkg::cmd_t             cmd;
  lclip_pkg::sts_t             sts;
  logic [4*COORD_BITS-1:0]     coords;

  lclip_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lclip_dp #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk        (clk),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_coords  (in_tdata[4*COORD_BITS-1:0]),
    .out_coords (coords),
    .out_inside (out_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .rst_n      (rst_n)
  );

  assign out_tdata = TW'(coords);

  `AST_NXT(a_one_in_work, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `AST_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_tvalid || out_tready)
  `AST_IMP(a_one_step, clk, rst_n, 1'b1,
           $onehot0({cmd.load, cmd.setup, cmd.mul_step, cmd.div_step, cmd.update}))

endmodule
